// ===== src/pet_pkg.sv =====
// Package with the shared types and constants of the pin edge trigger counter.
package pet_pkg;

  // Physical pin mask width and configuration bus widths.
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned CNT8_W    = 8;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Register byte addresses.
  localparam logic [PADDR_W-1:0] REG_EDGE_SELECT = 3'd0;

  // Item function codes; the remaining code is ignored.
  typedef enum logic [1:0] {
    FUNC_EDGE   = 2'd0,
    FUNC_ARM    = 2'd1,
    FUNC_REPORT = 2'd2
  } func_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_REPORT
  } state_e;

  // Input item.
  typedef struct packed {
    logic [1:0]        func;
    logic [MASK_W-1:0] pending_mask;
    logic [3:0]        pin_number;
    logic [CNT8_W-1:0] threshold;
    logic              enable;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [3:0] pin_index;
    logic       level;
    logic       last;
  } out_item_t;

  // Configuration handed from the register block to the engine.
  typedef struct packed {
    logic [MASK_W-1:0] edge_select;
  } cfg_t;

endpackage

// ===== src/pet_regs.sv =====
// APB-style configuration register block of the pin edge trigger counter.
module pet_regs
  import pet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [MASK_W-1:0] edge_sel_q;
  logic              wr_en;

  // A write completes in the access phase; the bus never waits.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_EDGE_SELECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_sel_q <= '0;
    end else if (wr_en) begin
      edge_sel_q <= pwdata[MASK_W-1:0];
    end
  end

  // Read data: the register at its address, zero elsewhere.
  always_comb begin
    prdata = '0;
    if (paddr == REG_EDGE_SELECT) begin
      prdata = {{(PDATA_W-MASK_W){1'b0}}, edge_sel_q};
    end
  end

  assign cfg_o.edge_select = edge_sel_q;

endmodule

// ===== src/pin_edge_trigger_counter.sv =====
// Top level of the pin edge trigger counter: sequencer, pin memory and output register.
//
//  Channel   Direction  Handshake                Payload
//  in        in         in_valid_i / in_ready_o  in_item_i  (in_item_t)
//  out       out        out_valid_o / out_ready_i out_item_o (out_item_t)
//  config    in         APB psel/penable/pwrite  paddr, pwdata, prdata
//
// An edge item walks the pin memory one pin per cycle through its registered
// read port. A report visits one pin per cycle, but stays on a marked pin while
// the output side holds a result. Reset is asynchronous; memory entries start
// invalid through per-entry valid bits and read as zero, so no clearing pass runs.
// The input side accepts only between items; a waiting result does not block it.
module pin_edge_trigger_counter
  import pet_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int unsigned ACTIVE_PINS = (PIN_COUNT < MASK_W) ? PIN_COUNT : MASK_W;
  localparam int unsigned PIN_W       = (ACTIVE_PINS > 1) ? $clog2(ACTIVE_PINS) : 1;
  localparam int unsigned PTR_W       = $clog2(ACTIVE_PINS + 1);
  localparam int unsigned ENT_W       = 2 * CNT8_W;
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(ACTIVE_PINS);

  cfg_t cfg;

  // Configuration registers.
  pet_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e                 state_q, state_d;
  logic [PTR_W-1:0]       ptr_q;
  logic [ACTIVE_PINS-1:0] pend_q;
  logic [ACTIVE_PINS-1:0] armed_q, armed_d;
  logic [ACTIVE_PINS-1:0] rise_q, rise_d;
  logic [ACTIVE_PINS-1:0] fall_q, fall_d;
  logic [ACTIVE_PINS-1:0] vld_q;
  logic                   s1_q;
  logic [PIN_W-1:0]       s1_pin_q;
  logic [ENT_W-1:0]       rd_q;
  logic [ENT_W-1:0]       mem [ACTIVE_PINS];

  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   in_xfer;
  func_e                  func;
  logic                   arm_hit;
  logic                   ptr_live;
  logic [PIN_W-1:0]       ptr_idx;
  logic                   edge_rd;
  logic                   rpt_marked;
  logic                   slot_free;
  logic                   load_out;
  logic                   advance;
  logic                   rest_marked;

  logic                   mem_we;
  logic [PIN_W-1:0]       mem_wa;
  logic [ENT_W-1:0]       mem_wd;

  logic [ENT_W-1:0]       ent;
  logic [CNT8_W-1:0]      ent_lim;
  logic [CNT8_W-1:0]      ent_inc;
  logic                   hit;
  logic                   trig;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign func     = func_e'(in_item_i.func);
  assign arm_hit  = ({1'b0, in_item_i.pin_number} < 5'(ACTIVE_PINS));
  assign ptr_live = (ptr_q < PTR_END);
  assign ptr_idx  = ptr_q[PIN_W-1:0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign rpt_marked = ptr_live && (rise_q[ptr_idx] || fall_q[ptr_idx]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && func == FUNC_EDGE) begin
          state_d = ST_EDGE;
        end else if (in_xfer && func == FUNC_REPORT) begin
          state_d = ST_REPORT;
        end
      end
      ST_EDGE: begin
        if (!ptr_live && !s1_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (!ptr_live) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    edge_rd    = 1'b0;
    load_out   = 1'b0;
    advance    = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EDGE: begin
        edge_rd = ptr_live;
        advance = ptr_live;
      end
      ST_REPORT: begin
        load_out = rpt_marked && slot_free;
        advance  = ptr_live && (!rpt_marked || slot_free);
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // Edge stage: modify the entry read in the previous cycle.
  assign ent     = vld_q[s1_pin_q] ? rd_q : '0;
  assign ent_lim = ent[ENT_W-1:CNT8_W];
  assign ent_inc = ent[CNT8_W-1:0] + CNT8_W'(1);
  assign hit     = s1_q && armed_q[s1_pin_q] && pend_q[s1_pin_q];
  assign trig    = (ent_inc >= ent_lim);

  // Memory write port: arm items in idle, counter updates in the edge walk.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_pin_q;
    mem_wd = {ent_lim, (trig ? {CNT8_W{1'b0}} : ent_inc)};
    if (in_xfer && func == FUNC_ARM && arm_hit) begin
      mem_we = 1'b1;
      mem_wa = in_item_i.pin_number[PIN_W-1:0];
      mem_wd = {in_item_i.threshold, {CNT8_W{1'b0}}};
    end else if (hit) begin
      mem_we = 1'b1;
    end
  end

  // Pin masks.
  always_comb begin
    armed_d = armed_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    if (in_xfer && func == FUNC_ARM && arm_hit) begin
      armed_d[in_item_i.pin_number[PIN_W-1:0]] = in_item_i.enable;
    end else if (hit && trig) begin
      if (ent_lim != '0) begin
        armed_d[s1_pin_q] = 1'b0;
      end
      rise_d[s1_pin_q] = cfg.edge_select[s1_pin_q];
      fall_d[s1_pin_q] = !cfg.edge_select[s1_pin_q];
    end
  end

  // Any mark above the pin being reported.
  always_comb begin
    rest_marked = 1'b0;
    for (int j = 0; j < ACTIVE_PINS; j++) begin
      if (j > int'(ptr_q) && (rise_q[j] || fall_q[j])) begin
        rest_marked = 1'b1;
      end
    end
  end

  // Pin memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (edge_rd) begin
      rd_q <= mem[ptr_idx];
    end
  end

  // Control and mask registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ptr_q    <= '0;
      armed_q  <= '0;
      rise_q   <= '0;
      fall_q   <= '0;
      vld_q    <= '0;
      s1_q     <= 1'b0;
      s1_pin_q <= '0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      s1_q    <= edge_rd;
      if (edge_rd) begin
        s1_pin_q <= ptr_idx;
      end
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (in_xfer) begin
        ptr_q <= '0;
      end else if (advance) begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  // Pending mask of the edge item being walked.
  always_ff @(posedge clk_i) begin
    if (in_xfer && func == FUNC_EDGE) begin
      pend_q <= in_item_i.pending_mask[ACTIVE_PINS-1:0];
    end
  end

  // Output register: a result waits here until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.pin_index <= 4'(ptr_idx);
      out_q.level     <= rise_q[ptr_idx];
      out_q.last      <= !rest_marked;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A pin never carries both marks.
  a_marks_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rise_q & fall_q) == '0)
    else $error("pin carries both rise and fall marks");

  // The memory is never written during a report.
  a_no_write_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPORT |-> !mem_we)
    else $error("pin memory written during report");

  // The edge stage only runs inside an edge walk.
  a_stage_in_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |-> state_q == ST_EDGE)
    else $error("edge stage active outside edge walk");

  // A result is loaded only into a free or draining output slot.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a waiting result");

  // After the final result of a report, the walk ends.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !rest_marked) |=> !load_out)
    else $error("result loaded after the final one");

endmodule
